@@ rtl/sequential_sampling_stop_rule_macros.svh @@
// Assertion macros for the stop rule block.
`ifndef SEQUENTIAL_SAMPLING_STOP_RULE_MACROS_SVH
`define SEQUENTIAL_SAMPLING_STOP_RULE_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define SSSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stop rule assertion failed");

// Clocked assertion that also holds during reset.
`define SSSR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("stop rule assertion failed");

`endif

@@ rtl/sssr_pkg.sv @@
// ---------------------------------------------------------------------------
// sssr_pkg
// Types, constants and tables shared by the stop rule block.
// ---------------------------------------------------------------------------
package sssr_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ENTRY_W     = 17;
  localparam logic [16:0] DEPTH_EXT = 17'(STORE_DEPTH);

  localparam int RANK_W  = 13;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 28;
  localparam int SQS_W   = 44;
  localparam int ACC_W   = 128;
  localparam int MOP_W   = 32;

  localparam logic [MOP_W-1:0] SCALE_15625 = 32'd15625;

  typedef struct packed {
    logic [RANK_W-1:0]  sample_rank;
    logic [VALUE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic              keep_sampling;
    logic [RANK_W-1:0] prefix_count;
    logic              rank_overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_CONFIDENCE = 2'd0,
    REG_DELTA      = 2'd1,
    REG_MIN        = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_APPLY,
    ST_TAKE,
    ST_TEST,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_ADV,
    ST_ADV_DATA,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_SS,
    OP_TQ,
    OP_LHS,
    OP_R1,
    OP_R2,
    OP_R3
  } mul_op_e;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] a;
    logic [MOP_W-1:0] b;
  } mul_req_t;

  // z^2 in units of 1e-6
  function automatic logic [22:0] z_sq(input logic [2:0] code);
    logic [22:0] r;
    case (code)
      3'd1:    r = 23'd1643524;
      3'd2:    r = 23'd2706025;
      3'd3:    r = 23'd3841600;
      3'd4:    r = 23'd5410276;
      3'd5:    r = 23'd6635776;
      default: r = 23'd1000000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/sssr_ram.sv @@
// ---------------------------------------------------------------------------
// sssr_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module sssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sssr_mul.sv @@
// ---------------------------------------------------------------------------
// sssr_mul
// Wide by 32-bit multiplier, one 32x32 partial product per cycle.
// ---------------------------------------------------------------------------
module sssr_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sssr_pkg::mul_req_t             req_i,
  output logic                           done_o,
  output logic [sssr_pkg::ACC_W-1:0]     p_o
);

  logic [sssr_pkg::ACC_W-1:0] a_q, a_d;
  logic [sssr_pkg::MOP_W-1:0] b_q, b_d;
  logic [sssr_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [63:0]                prod;

  assign prod = a_q[31:0] * b_q;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d   = req_i.a;
      b_d   = req_i.b;
      acc_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = acc_q + ({64'd0, prod} << {cnt_q, 5'd0});
      a_d   = a_q >> 32;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ rtl/sequential_sampling_stop_rule.sv @@
// ---------------------------------------------------------------------------
// sequential_sampling_stop_rule
// Out-of-order sample store with running prefix sums and a squared,
// division-free confidence interval stop test.
// ---------------------------------------------------------------------------
// channel | signals                              | direction
// in      | in_valid_i, in_stall_o, in_data_i    | sample transactions in
// out     | out_valid_o, out_stall_i, out_data_o | one result per sample
// cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register writes
//
// After reset a clearing pass writes all STORE_DEPTH (4096) entries; in_stall_o is high.
// Each in-range sample takes a store lookup and update plus one store read per
// prefix step and, once the prefix reaches min_samples, six passes per step
// through the wide multiplier. The single store port and shared multiplier
// serialise this work.
// The result register lets a new sample enter while a result is stalled.
// ---------------------------------------------------------------------------
module sequential_sampling_stop_rule (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sssr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sssr_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  sssr_pkg::state_e  state_q, state_d;
  sssr_pkg::mul_op_e op_q, op_d;

  logic [sssr_pkg::ADDR_W-1:0]  clr_q;
  logic [2:0]                   conf_q;
  logic [15:0]                  delta_q;
  logic [12:0]                  min_q;
  logic [31:0]                  dsq_q;

  logic [sssr_pkg::RANK_W-1:0]  t_q;
  logic [sssr_pkg::SUM_W-1:0]   s_q;
  logic [sssr_pkg::SQS_W-1:0]   q_q;

  logic [sssr_pkg::RANK_W-1:0]  rank_q;
  logic [sssr_pkg::VALUE_W-1:0] val_q, old_q;
  logic [31:0]                  sq_old_q, sq_new_q;
  logic                         keep_q, ovf_q;

  logic [55:0]                  ss_q;
  logic [56:0]                  dev_q;
  logic [sssr_pkg::ACC_W-1:0]   lhs_q, r_q;

  logic                         out_valid_q;
  sssr_pkg::out_item_t          out_q;

  logic                         in_acc;
  logic                         ram_we;
  logic [sssr_pkg::ADDR_W-1:0]  ram_wa, ram_ra;
  logic [sssr_pkg::ENTRY_W-1:0] ram_wd, ram_rd;
  logic                         rd_present;
  logic [sssr_pkg::VALUE_W-1:0] rd_value;
  logic [sssr_pkg::ADDR_W-1:0]  rank_idx;
  logic                         out_free;

  sssr_pkg::mul_req_t           mreq;
  logic                         mdone;
  logic [sssr_pkg::ACC_W-1:0]   mp;

  assign in_stall_o  = (state_q != sssr_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign rd_present  = ram_rd[16];
  assign rd_value    = ram_rd[15:0];
  assign rank_idx    = sssr_pkg::ADDR_W'(rank_q - 13'd1);
  assign out_free    = !out_valid_q || !out_stall_i;

  sssr_ram #(
    .WIDTH(sssr_pkg::ENTRY_W),
    .DEPTH(sssr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  sssr_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .p_o    (mp)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      sssr_pkg::ST_CLEAR: begin
        if (clr_q == sssr_pkg::ADDR_W'(sssr_pkg::STORE_DEPTH - 1)) begin
          state_d = sssr_pkg::ST_IDLE;
        end
      end
      sssr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (17'(in_data_i.sample_rank) > sssr_pkg::DEPTH_EXT ||
              in_data_i.sample_rank == '0) begin
            state_d = sssr_pkg::ST_DONE;
          end else begin
            state_d = sssr_pkg::ST_LOOK;
          end
        end
      end
      sssr_pkg::ST_LOOK: state_d = sssr_pkg::ST_APPLY;
      sssr_pkg::ST_APPLY: begin
        if (rank_q == t_q + 13'd1) begin
          state_d = sssr_pkg::ST_TAKE;
        end else begin
          state_d = sssr_pkg::ST_DONE;
        end
      end
      sssr_pkg::ST_TAKE: state_d = sssr_pkg::ST_TEST;
      sssr_pkg::ST_TEST: begin
        if (t_q < min_q) begin
          state_d = sssr_pkg::ST_ADV;
        end else begin
          op_d    = sssr_pkg::OP_SS;
          state_d = sssr_pkg::ST_MUL_GO;
        end
      end
      sssr_pkg::ST_MUL_GO: state_d = sssr_pkg::ST_MUL_WAIT;
      sssr_pkg::ST_MUL_WAIT: begin
        if (mdone) begin
          if (op_q == sssr_pkg::OP_R3) begin
            state_d = (lhs_q > mp) ? sssr_pkg::ST_ADV : sssr_pkg::ST_DONE;
          end else begin
            op_d    = sssr_pkg::mul_op_e'(op_q + 3'd1);
            state_d = sssr_pkg::ST_MUL_GO;
          end
        end
      end
      sssr_pkg::ST_ADV: begin
        state_d = (17'(t_q) < sssr_pkg::DEPTH_EXT) ? sssr_pkg::ST_ADV_DATA
                                                   : sssr_pkg::ST_DONE;
      end
      sssr_pkg::ST_ADV_DATA: begin
        state_d = rd_present ? sssr_pkg::ST_TAKE : sssr_pkg::ST_DONE;
      end
      sssr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sssr_pkg::ST_IDLE;
        end
      end
      default: state_d = sssr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = rank_idx;
    ram_wd = {1'b1, val_q};
    ram_ra = t_q[sssr_pkg::ADDR_W-1:0];
    mreq   = '0;
    unique case (state_q)
      sssr_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        ram_wd = '0;
      end
      sssr_pkg::ST_IDLE: begin
        ram_ra = sssr_pkg::ADDR_W'(in_data_i.sample_rank - 13'd1);
      end
      sssr_pkg::ST_APPLY: ram_we = 1'b1;
      sssr_pkg::ST_MUL_GO: begin
        mreq.start = 1'b1;
        case (op_q)
          sssr_pkg::OP_SS: begin
            mreq.a = 128'(s_q);
            mreq.b = 32'(s_q);
          end
          sssr_pkg::OP_TQ: begin
            mreq.a = 128'(q_q);
            mreq.b = 32'(t_q);
          end
          sssr_pkg::OP_LHS: begin
            mreq.a = 128'(dev_q);
            mreq.b = 32'(sssr_pkg::z_sq(conf_q));
          end
          sssr_pkg::OP_R1: begin
            mreq.a = 128'(ss_q);
            mreq.b = 32'(t_q);
          end
          sssr_pkg::OP_R2: begin
            mreq.a = r_q;
            mreq.b = dsq_q;
          end
          default: begin
            mreq.a = r_q;
            mreq.b = sssr_pkg::SCALE_15625;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sssr_pkg::ST_CLEAR;
      op_q        <= sssr_pkg::OP_SS;
      clr_q       <= '0;
      conf_q      <= 3'd3;
      delta_q     <= 16'd3277;
      min_q       <= 13'd30;
      t_q         <= '0;
      s_q         <= '0;
      q_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (state_q == sssr_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          sssr_pkg::REG_CONFIDENCE: conf_q  <= cfg_data_i[2:0];
          sssr_pkg::REG_DELTA:      delta_q <= cfg_data_i;
          sssr_pkg::REG_MIN:        min_q   <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (state_q == sssr_pkg::ST_APPLY && rank_q <= t_q) begin
        s_q <= s_q - sssr_pkg::SUM_W'(old_q) + sssr_pkg::SUM_W'(val_q);
        q_q <= q_q - sssr_pkg::SQS_W'(sq_old_q) + sssr_pkg::SQS_W'(sq_new_q);
      end
      if (state_q == sssr_pkg::ST_TAKE) begin
        t_q <= t_q + 13'd1;
        s_q <= s_q + sssr_pkg::SUM_W'(val_q);
        q_q <= q_q + sssr_pkg::SQS_W'(sq_new_q);
      end
      if (state_q == sssr_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dsq_q <= delta_q * delta_q;
    if (in_acc) begin
      rank_q <= in_data_i.sample_rank;
      val_q  <= in_data_i.sample_value;
      keep_q <= 1'b1;
      ovf_q  <= 17'(in_data_i.sample_rank) > sssr_pkg::DEPTH_EXT;
      if (17'(in_data_i.sample_rank) > sssr_pkg::DEPTH_EXT) begin
        keep_q <= 1'b0;
      end
    end
    if (state_q == sssr_pkg::ST_LOOK) begin
      old_q    <= rd_value;
      sq_old_q <= rd_value * rd_value;
      sq_new_q <= val_q * val_q;
    end
    if (state_q == sssr_pkg::ST_ADV_DATA) begin
      val_q    <= rd_value;
      sq_new_q <= rd_value * rd_value;
    end
    if (state_q == sssr_pkg::ST_MUL_WAIT && mdone) begin
      case (op_q)
        sssr_pkg::OP_SS:  ss_q  <= mp[55:0];
        sssr_pkg::OP_TQ:  dev_q <= (mp[56:0] > 57'(ss_q)) ? mp[56:0] - 57'(ss_q) : '0;
        sssr_pkg::OP_LHS: lhs_q <= mp << 26;
        sssr_pkg::OP_R1:  r_q   <= mp;
        sssr_pkg::OP_R2:  r_q   <= mp;
        default: begin
          if (!(lhs_q > mp)) begin
            keep_q <= 1'b0;
          end
        end
      endcase
    end
    if (state_q == sssr_pkg::ST_DONE && out_free) begin
      out_q.keep_sampling <= keep_q;
      out_q.prefix_count  <= t_q;
      out_q.rank_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/sssr_checker.sv @@
// ---------------------------------------------------------------------------
// sssr_checker
// Port-level checks on the stop rule block, bound to the top level.
// ---------------------------------------------------------------------------
`include "sequential_sampling_stop_rule_macros.svh"

module sssr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sssr_pkg::out_item_t out_data_o
);

  `SSSR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `SSSR_ASSERT(a_ovf_stops, out_valid_o && out_data_o.rank_overflow |-> !out_data_o.keep_sampling)
  `SSSR_ASSERT(a_count_range, out_valid_o |-> 17'(out_data_o.prefix_count) <= sssr_pkg::DEPTH_EXT)
  `SSSR_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  `SSSR_ASSERT_ALWAYS(a_reset_idle_out, !rst_ni |-> !out_valid_o)

endmodule

bind sequential_sampling_stop_rule sssr_checker u_sssr_checker (.*);

@@ sim/sequential_sampling_stop_rule_tb.sv @@
// ---------------------------------------------------------------------------
// sequential_sampling_stop_rule_tb
// Self-checking bench for the out-of-order sample store and prefix stop test.
// A directed table covers reset values, field extremes, overflow, ignored and
// overwritten ranks, and a zero prefix sum. Random phases under several
// register settings follow, checked against an in-bench predictor. The sender
// gaps its samples at random, the receiver stalls in random bursts and holds
// off once for a long stretch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_sampling_stop_rule_tb;

  localparam int  DEPTH       = sssr_pkg::STORE_DEPTH;
  localparam int  PHASE_ITEMS = 220;
  localparam int  NUM_PHASES  = 5;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit                  is_cfg;
    bit                  typed;
    sssr_pkg::reg_idx_e  ridx;
    logic [12:0]         rank;
    logic [15:0]         value;
    sssr_pkg::out_item_t exp;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  sssr_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  sssr_pkg::out_item_t out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [15:0]         cfg_data_i;

  // predictor state
  logic [15:0] store_mem [DEPTH];
  bit          present   [DEPTH];
  logic [63:0] plen;
  logic [63:0] psum;
  logic [63:0] psq;
  logic [2:0]  zcode;
  logic [15:0] dfrac;
  logic [12:0] minlen;

  sssr_pkg::out_item_t results_q[$];
  row_t      rows[$];
  int        mismatches;
  int        items_sent;
  int        results_seen;
  int        stops_seen;
  int        ovf_seen;
  longint    cycles;
  bit        quiet;
  bit        hold_req;
  bit        hold_active;

  sequential_sampling_stop_rule DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] z_milli(logic [2:0] code);
    case (code)
      3'd1:    return 64'd1282;
      3'd2:    return 64'd1645;
      3'd3:    return 64'd1960;
      3'd4:    return 64'd2326;
      3'd5:    return 64'd2576;
      default: return 64'd1000;
    endcase
  endfunction

  function automatic bit keeps_going();
    logic [63:0]  ss;
    logic [63:0]  tq;
    logic [63:0]  dev;
    logic [63:0]  zm;
    logic [127:0] lhs;
    logic [127:0] rhs;
    if (plen < 64'(minlen)) return 1'b1;
    ss  = psum * psum;
    tq  = plen * psq;
    dev = (tq > ss) ? tq - ss : 64'd0;
    zm  = z_milli(zcode);
    lhs = 128'(dev) * 128'(zm * zm);
    lhs = lhs << 26;
    rhs = 128'(ss) * 128'(plen);
    rhs = rhs * 128'(64'(dfrac) * 64'(dfrac));
    rhs = rhs * 128'd15625;
    return lhs > rhs;
  endfunction

  function automatic void extend_prefix(logic [15:0] v);
    plen = plen + 1;
    psum = psum + 64'(v);
    psq  = psq + 64'(v) * 64'(v);
  endfunction

  function automatic sssr_pkg::out_item_t predict_sample(logic [12:0] rank, logic [15:0] v);
    sssr_pkg::out_item_t r;
    logic [63:0]         old;
    int                  idx;
    r.keep_sampling = 1'b1;
    r.rank_overflow = 1'b0;
    if (int'(rank) > DEPTH) begin
      r.keep_sampling = 1'b0;
      r.rank_overflow = 1'b1;
    end else if (rank != 0) begin
      idx = int'(rank) - 1;
      if (64'(rank) <= plen) begin
        old = 64'(store_mem[idx]);
        psum = psum - old + 64'(v);
        psq  = psq - old * old + 64'(v) * 64'(v);
        store_mem[idx] = v;
      end else begin
        store_mem[idx] = v;
        present[idx] = 1'b1;
        if (64'(rank) == plen + 1) begin
          extend_prefix(v);
          if (!keeps_going()) begin
            r.keep_sampling = 1'b0;
          end else begin
            while (plen < DEPTH && present[plen]) begin
              extend_prefix(store_mem[plen]);
              if (!keeps_going()) begin
                r.keep_sampling = 1'b0;
                break;
              end
            end
          end
        end
      end
    end
    r.prefix_count = plen[12:0];
    return r;
  endfunction

  task automatic wait_drained();
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(sssr_pkg::reg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sssr_pkg::REG_CONFIDENCE: zcode  = data[2:0];
      sssr_pkg::REG_DELTA:      dfrac  = data;
      default:                  minlen = data[12:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(logic [12:0] rank, logic [15:0] v, bit typed,
                             sssr_pkg::out_item_t exp);
    sssr_pkg::out_item_t pred;
    @(negedge clk_i);
    if (!quiet && !hold_active && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.sample_rank  <= rank;
    in_data_i.sample_value <= v;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_sample(rank, v);
    results_q.push_back(typed ? exp : pred);
    items_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (!out_data_o.keep_sampling) stops_seen++;
      if (out_data_o.rank_overflow) ovf_seen++;
      if (results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: keep=%0b count=%0d ovf=%0b",
                   out_data_o.keep_sampling, out_data_o.prefix_count,
                   out_data_o.rank_overflow);
      end else begin
        if (out_data_o !== results_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp keep=%0b count=%0d ovf=%0b, got keep=%0b count=%0d ovf=%0b",
                     results_q[0].keep_sampling, results_q[0].prefix_count,
                     results_q[0].rank_overflow, out_data_o.keep_sampling,
                     out_data_o.prefix_count, out_data_o.rank_overflow);
        end
        void'(results_q.pop_front());
      end
    end
  end

  // receiver stall bursts and one long hold-off
  initial begin
    int n;
    out_stall_i = 1'b1;
    forever begin
      if (quiet) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (hold_req) begin
        repeat (400) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_value(int base, int spread);
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
    end
    if (sel < 90) return 16'($urandom);
    return (sel < 95) ? 16'd0 : 16'hFFFF;
  endfunction

  function automatic logic [12:0] pick_rank();
    int sel;
    int r;
    sel = $urandom_range(0, 99);
    if (sel < 70 || (sel < 82 && plen == 0)) begin
      r = int'(plen) + 1 + int'($urandom_range(0, 4));
      if (r > DEPTH) r = DEPTH;
    end else if (sel < 82) begin
      r = $urandom_range(1, int'(plen));
    end else if (sel < 88) begin
      r = 0;
    end else if (sel < 94) begin
      r = $urandom_range(DEPTH + 1, 8191);
    end else begin
      r = $urandom_range(1, DEPTH);
    end
    return 13'(r);
  endfunction

  task automatic add_item(int rank, int v, bit typed, bit k, int cnt, bit o);
    row_t r;
    r.is_cfg = 1'b0;
    r.typed  = typed;
    r.ridx   = sssr_pkg::REG_CONFIDENCE;
    r.rank   = 13'(rank);
    r.value  = 16'(v);
    r.exp.keep_sampling = k;
    r.exp.prefix_count  = 13'(cnt);
    r.exp.rank_overflow = o;
    rows.push_back(r);
  endtask

  task automatic add_cfg(sssr_pkg::reg_idx_e idx, int data);
    row_t r;
    r.is_cfg = 1'b1;
    r.typed  = 1'b0;
    r.ridx   = idx;
    r.rank   = '0;
    r.value  = 16'(data);
    r.exp    = '0;
    rows.push_back(r);
  endtask

  initial begin
    int base;
    int spread;
    int max_prefix;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    items_sent  = 0;
    results_seen = 0;
    stops_seen  = 0;
    ovf_seen    = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    max_prefix  = 0;
    for (int i = 0; i < DEPTH; i++) begin
      store_mem[i] = '0;
      present[i]   = 1'b0;
    end
    plen   = 0;
    psum   = 0;
    psq    = 0;
    zcode  = 3'd3;
    dfrac  = 16'd3277;
    minlen = 13'd30;

    add_item(0,    16'hFFFF, 1, 1, 0, 0);
    add_item(4097, 1234,     1, 0, 0, 1);
    add_item(8191, 0,        1, 0, 0, 1);
    add_item(3,    5,        1, 1, 0, 0);
    add_item(3,    7,        1, 1, 0, 0);
    add_item(4096, 16'hFFFF, 1, 1, 0, 0);
    add_item(1,    0,        1, 1, 1, 0);
    add_item(2,    16'hFFFF, 1, 1, 3, 0);
    add_item(1,    16'hFFFF, 1, 1, 3, 0);
    add_item(2,    0,        0, 0, 0, 0);
    add_cfg(sssr_pkg::REG_MIN, 1);
    add_cfg(sssr_pkg::REG_DELTA, 0);
    add_cfg(sssr_pkg::REG_CONFIDENCE, 7);
    add_item(1,    0,        0, 0, 0, 0);
    add_item(3,    0,        0, 0, 0, 0);
    add_item(4,    0,        0, 0, 0, 0);
    add_item(5,    100,      0, 0, 0, 0);
    add_item(5,    100,      0, 0, 0, 0);
    add_cfg(sssr_pkg::REG_DELTA, 65535);
    add_cfg(sssr_pkg::REG_CONFIDENCE, 0);
    add_item(6,    100,      0, 0, 0, 0);
    add_item(8,    3,        0, 0, 0, 0);
    add_item(7,    65535,    0, 0, 0, 0);
    add_cfg(sssr_pkg::REG_CONFIDENCE, 5);
    add_cfg(sssr_pkg::REG_DELTA, 3277);
    add_cfg(sssr_pkg::REG_MIN, 2);
    add_item(9,    1000,     0, 0, 0, 0);
    add_item(10,   1010,     0, 0, 0, 0);
    add_item(11,   990,      0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        idle_sender();
        wait_drained();
        write_reg(rows[i].ridx, rows[i].value);
      end else begin
        send_sample(rows[i].rank, rows[i].value, rows[i].typed, rows[i].exp);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_sender();
      wait_drained();
      case (ph)
        0: begin
          write_reg(sssr_pkg::REG_CONFIDENCE, 16'd0);
          write_reg(sssr_pkg::REG_DELTA, 16'd0);
          write_reg(sssr_pkg::REG_MIN, 16'd1);
        end
        1: begin
          write_reg(sssr_pkg::REG_CONFIDENCE, 16'd5);
          write_reg(sssr_pkg::REG_DELTA, 16'd65535);
          write_reg(sssr_pkg::REG_MIN, 16'd4096);
        end
        2: begin
          write_reg(sssr_pkg::REG_CONFIDENCE, 16'd7);
          write_reg(sssr_pkg::REG_DELTA, 16'($urandom));
          write_reg(sssr_pkg::REG_MIN, 16'($urandom_range(1, 60)));
        end
        3: begin
          write_reg(sssr_pkg::REG_CONFIDENCE, 16'($urandom_range(0, 7)));
          write_reg(sssr_pkg::REG_DELTA, 16'($urandom));
          write_reg(sssr_pkg::REG_MIN, 16'($urandom_range(1, 200)));
        end
        default: begin
          write_reg(sssr_pkg::REG_CONFIDENCE, 16'd6);
          write_reg(sssr_pkg::REG_DELTA, 16'($urandom_range(500, 6000)));
          write_reg(sssr_pkg::REG_MIN, 16'($urandom_range(1, 40)));
        end
      endcase
      base   = $urandom_range(100, 60000);
      spread = $urandom_range(0, 3000);
      if (ph == 2) begin
        hold_active = 1'b1;
        hold_req    = 1'b1;
      end
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(pick_rank(), pick_value(base, spread), 1'b0, '0);
        if (int'(plen) > max_prefix) max_prefix = int'(plen);
      end
    end

    idle_sender();
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d samples sent, %0d results checked (%0d stops, %0d overflows)",
             items_sent, results_seen, stops_seen, ovf_seen);
    $display("longest prefix %0d, %0d mismatches", max_prefix, mismatches);
    if (mismatches == 0 && results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
